// ===== design/bsc_pkg.sv =====
// Shared types and constants for the bitmap store with set, get and count.
package bsc_pkg;

  // Width of a byte index taken from a 16-bit bit offset.
  localparam int BYTE_IDX_W = 13;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;

  // Mode codes carried in a request.
  localparam logic [2:0] MODE_SET         = 3'd0;
  localparam logic [2:0] MODE_GET         = 3'd1;
  localparam logic [2:0] MODE_COUNT_ALL   = 3'd2;
  localparam logic [2:0] MODE_COUNT_RANGE = 3'd3;
  localparam logic [2:0] MODE_CLEAR       = 3'd4;
  localparam logic [2:0] MODE_STATUS      = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] bit_offset;
    logic        bit_value;
    logic [15:0] start_byte;
    logic [15:0] end_byte;
  } req_t;

  typedef struct packed {
    logic        bit_out;
    logic        changed;
    logic [15:0] ones_count;
    logic [12:0] length_bytes;
    logic        is_empty;
    logic        out_of_range;
  } res_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_GET,
    OP_COUNT_ALL,
    OP_COUNT_RANGE,
    OP_CLEAR,
    OP_STATUS
  } op_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [2:0]            bit_idx;
    logic                  bit_value;
    logic                  oor;
    logic                  range_ok;
    logic [15:0]           start_byte;
    logic [15:0]           end_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_COUNT,
    ST_TAIL,
    ST_EMIT
  } back_state_t;

endpackage

// ===== design/bitmap_store_set_get_count_core.sv =====
// Top level of the bitmap store with bit set, bit get and population count.
//
//   channel   signals                          direction   carries
//   request   req_valid, req_stall, req_data   in          bsc_pkg::req_t
//   result    res_valid, res_stall, res_data   out         bsc_pkg::res_t
//
// In the back end, get, status, clear and a set inside the current length go
// through command pop with store read, then read-modify-write and result.
// A set that grows the bitmap first zeroes each byte added below its own byte
// through the store write port, then writes its own byte and gives the result.
// Count modes make one store read per counted byte before the result, and take
// the short path through the read state when there is nothing to count.
// Reset is synchronous and clears the length, so no clearing pass is needed.
// A stalled result waits in the output register while the queue keeps taking
// requests until it is full.
module bitmap_store_set_get_count_core #(
  parameter int DEPTH_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bsc_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output bsc_pkg::res_t res_data
);

  // Classified command from the front end and the queue head seen by the back end.
  bsc_pkg::cmd_t front_cmd;
  bsc_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;

  // The front end decodes the mode, splits the bit offset and flags a set
  // beyond the capacity; it stalls the request channel only when the queue is full.
  bsc_front #(
    .DEPTH_BYTES (DEPTH_BYTES)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd       (front_cmd)
  );

  // Two-entry queue so the front can take requests while the back is busy.
  bsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_cmd)
  );

  // The back end owns the byte store and the length. Every byte below the
  // length holds a defined value, because growth zeroes the bytes it adds,
  // so an unwritten byte inside the bitmap reads as zero.
  bsc_back #(
    .DEPTH_BYTES (DEPTH_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (head_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// ===== design/bsc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bsc_front.sv =====
// Front end: accepts requests and classifies them into commands for the queue.
module bsc_front #(
  parameter int DEPTH_BYTES = 4096
) (
  input  logic          req_valid,
  output logic          req_stall,
  input  bsc_pkg::req_t req_data,
  input  logic          q_full,
  output logic          q_push,
  output bsc_pkg::cmd_t cmd
);

  localparam int LW = $clog2(DEPTH_BYTES + 1);
  localparam int CW = (LW > 16) ? LW : 16;

  logic [CW-1:0] byte_wide;

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;
  assign byte_wide = CW'(req_data.bit_offset[15:3]);

  always_comb begin
    case (req_data.mode)
      bsc_pkg::MODE_SET:         cmd.op = bsc_pkg::OP_SET;
      bsc_pkg::MODE_GET:         cmd.op = bsc_pkg::OP_GET;
      bsc_pkg::MODE_COUNT_ALL:   cmd.op = bsc_pkg::OP_COUNT_ALL;
      bsc_pkg::MODE_COUNT_RANGE: cmd.op = bsc_pkg::OP_COUNT_RANGE;
      bsc_pkg::MODE_CLEAR:       cmd.op = bsc_pkg::OP_CLEAR;
      default:                   cmd.op = bsc_pkg::OP_STATUS;
    endcase
    cmd.byte_idx   = req_data.bit_offset[15:3];
    cmd.bit_idx    = req_data.bit_offset[2:0];
    cmd.bit_value  = req_data.bit_value;
    // Only a set reports a byte beyond the capacity.
    cmd.oor        = (req_data.mode == bsc_pkg::MODE_SET) &&
                     (byte_wide >= CW'(DEPTH_BYTES));
    cmd.range_ok   = req_data.start_byte <= req_data.end_byte;
    cmd.start_byte = req_data.start_byte;
    cmd.end_byte   = req_data.end_byte;
  end

endmodule

// ===== design/bsc_queue.sv =====
// Short command queue that decouples the front end from the back end.
module bsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsc_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output bsc_pkg::cmd_t rd_data
);

  bsc_pkg::cmd_t                 slots [bsc_pkg::QUEUE_DEPTH];
  logic [bsc_pkg::QPTR_W-1:0]    wptr;
  logic [bsc_pkg::QPTR_W-1:0]    rptr;
  logic [bsc_pkg::QPTR_W:0]      fill;

  assign full     = fill == (bsc_pkg::QPTR_W + 1)'(bsc_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

// ===== design/bsc_back.sv =====
// Back end: sequencer that executes commands against the byte store.
module bsc_back #(
  parameter int DEPTH_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bsc_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          res_valid,
  input  logic          res_stall,
  output bsc_pkg::res_t res_data
);

  localparam int AW = $clog2(DEPTH_BYTES);
  localparam int LW = $clog2(DEPTH_BYTES + 1);
  localparam int CW = (LW > 16) ? LW : 16;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

  bsc_pkg::back_state_t state;
  bsc_pkg::back_state_t state_next;
  bsc_pkg::cmd_t        cmd;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        last;
  logic [15:0]          acc;
  logic                 primed;
  logic [LW-1:0]        length;

  logic                 out_free;
  logic                 emit;
  bsc_pkg::res_t        res;
  logic [LW-1:0]        len_after;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;

  logic [CW-1:0]        len_wide;
  logic [CW-1:0]        head_byte_wide;
  logic [CW-1:0]        cmd_byte_wide;
  logic [CW-1:0]        range_last;
  logic [AW-1:0]        cmd_addr;
  logic                 head_grows;
  logic                 count_go;
  logic                 cmd_in_len;
  logic [7:0]           bit_mask;
  logic [7:0]           new_byte;

  assign out_free       = !res_valid || !res_stall;
  assign len_wide       = CW'(length);
  assign head_byte_wide = CW'(q_data.byte_idx);
  assign cmd_byte_wide  = CW'(cmd.byte_idx);
  assign cmd_addr       = cmd_byte_wide[AW-1:0];
  assign cmd_in_len     = cmd_byte_wide < len_wide;
  assign bit_mask       = 8'h01 << cmd.bit_idx;
  assign new_byte       = cmd.bit_value ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
  assign head_grows     = (q_data.op == bsc_pkg::OP_SET) && !q_data.oor &&
                          (head_byte_wide >= len_wide);
  assign range_last     = (CW'(q_data.end_byte) >= len_wide) ? (len_wide - 1'b1)
                                                             : CW'(q_data.end_byte);

  always_comb begin
    case (q_data.op)
      bsc_pkg::OP_COUNT_ALL:   count_go = length != '0;
      bsc_pkg::OP_COUNT_RANGE: count_go = q_data.range_ok &&
                                          (CW'(q_data.start_byte) < len_wide);
      default:                 count_go = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bsc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (head_grows) begin
            state_next = bsc_pkg::ST_FILL;
          end else if (count_go) begin
            state_next = bsc_pkg::ST_COUNT;
          end else begin
            state_next = bsc_pkg::ST_READ;
          end
        end
      end
      bsc_pkg::ST_READ: begin
        if (out_free) begin
          state_next = bsc_pkg::ST_IDLE;
        end
      end
      bsc_pkg::ST_FILL: begin
        if (ptr == cmd_addr && out_free) begin
          state_next = bsc_pkg::ST_IDLE;
        end
      end
      bsc_pkg::ST_COUNT: begin
        if (ptr == last) begin
          state_next = bsc_pkg::ST_TAIL;
        end
      end
      bsc_pkg::ST_TAIL: state_next = bsc_pkg::ST_EMIT;
      bsc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = bsc_pkg::ST_IDLE;
        end
      end
      default: state_next = bsc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store access, queue pop and the result.
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cmd_addr;
    ram_wdata = new_byte;
    ram_raddr = cmd_addr;
    len_after = length;
    res       = '0;
    case (state)
      bsc_pkg::ST_IDLE: begin
        q_pop     = q_valid;
        ram_raddr = head_byte_wide[AW-1:0];
      end
      bsc_pkg::ST_READ: begin
        emit = out_free;
        case (cmd.op)
          bsc_pkg::OP_SET: begin
            res.out_of_range = cmd.oor;
            res.changed      = !cmd.oor && (ram_rdata[cmd.bit_idx] != cmd.bit_value);
            ram_we           = out_free && !cmd.oor;
          end
          bsc_pkg::OP_GET:   res.bit_out = cmd_in_len && ram_rdata[cmd.bit_idx];
          bsc_pkg::OP_CLEAR: len_after = '0;
          default:           res.bit_out = 1'b0;
        endcase
      end
      bsc_pkg::ST_FILL: begin
        ram_waddr = ptr;
        if (ptr != cmd_addr) begin
          // Bytes added below the new byte read as zero.
          ram_we    = 1'b1;
          ram_wdata = '0;
        end else begin
          ram_we      = out_free;
          ram_wdata   = cmd.bit_value ? bit_mask : 8'h00;
          emit        = out_free;
          res.changed = cmd.bit_value;
          len_after   = LW'(cmd_byte_wide + 1'b1);
        end
      end
      bsc_pkg::ST_COUNT: ram_raddr = ptr;
      bsc_pkg::ST_EMIT: begin
        emit           = out_free;
        res.ones_count = acc;
      end
      default: emit = 1'b0;
    endcase
    res.length_bytes = 13'(len_after);
    res.is_empty     = len_after == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bsc_pkg::ST_IDLE;
      length    <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        length <= len_after;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_data <= res;
    end
    case (state)
      bsc_pkg::ST_IDLE: begin
        cmd    <= q_data;
        acc    <= '0;
        primed <= 1'b0;
        if (head_grows) begin
          ptr <= length[AW-1:0];
        end else if (q_data.op == bsc_pkg::OP_COUNT_ALL) begin
          ptr  <= '0;
          last <= AW'(len_wide - 1'b1);
        end else begin
          ptr  <= AW'(q_data.start_byte);
          last <= range_last[AW-1:0];
        end
      end
      bsc_pkg::ST_FILL: begin
        if (ptr != cmd_addr) begin
          ptr <= ptr + 1'b1;
        end
      end
      bsc_pkg::ST_COUNT: begin
        primed <= 1'b1;
        if (primed) begin
          acc <= acc + {12'd0, popcount8(ram_rdata)};
        end
        if (ptr != last) begin
          ptr <= ptr + 1'b1;
        end
      end
      bsc_pkg::ST_TAIL: acc <= acc + {12'd0, popcount8(ram_rdata)};
      default: acc <= acc;
    endcase
  end

  bsc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == bsc_pkg::ST_READ || state == bsc_pkg::ST_FILL))
    else $error("store written outside a set");

  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    len_wide <= CW'(DEPTH_BYTES))
    else $error("length beyond capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bsc_pkg::ST_COUNT) |-> (ptr <= last && CW'(last) < len_wide))
    else $error("count walk outside the bitmap");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (emit && state == bsc_pkg::ST_READ && cmd.op == bsc_pkg::OP_CLEAR) |=> (length == '0))
    else $error("clear left a nonzero length");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the bitmap store with bit set, bit get and population count.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = 4096;

  // Mode codes that the package leaves unnamed. The block must treat them as no-ops.
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  // The slowest single request walks the full store, so a watchdog limit several
  // times as long as that walk covers every correct run.
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_PCT       = 18;
  localparam int SETTLE_CYCLES  = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bsc_pkg::req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  bsc_pkg::res_t res_data;

  always #6 clk = ~clk;

  bitmap_store_set_get_count_core #(
    .DEPTH_BYTES(STORE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data)
  );

  // Shadow copy of the bitmap. A byte is only trusted when its written mark
  // is set, so stale contents left behind by a clear never leak into a read.
  logic [7:0]  bm_bytes [STORE_BYTES];
  bit          bm_marked [STORE_BYTES];
  int unsigned bm_len = 0;

  bsc_pkg::res_t expected_results [$];
  int   error_count = 0;
  int   sent_count = 0;

  // Idle rates for both sides, in percent of cycles. The tests lower them to
  // zero for the stretches that must run back to back.
  int req_idle_pct = IDLE_PCT;
  int res_idle_pct = IDLE_PCT;

  // A test asks for a long result hold-off by bumping hold_asked. The stall
  // process notices the change and counts the hold-off down on its own.
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Byte as the block sees it: zero beyond the length or when never written
  // since the last clear.
  function automatic logic [7:0] stored_byte(input int unsigned idx);
    if (idx >= STORE_BYTES || idx >= bm_len || !bm_marked[idx]) return 8'h00;
    return bm_bytes[idx];
  endfunction

  function automatic int unsigned ones_over_bytes(input int unsigned first,
                                                  input int unsigned last);
    int unsigned total;
    total = 0;
    for (int unsigned i = first; i <= last; i++) total += $countones(stored_byte(i));
    return total;
  endfunction

  // Applies one request to the shadow bitmap and returns the result that the
  // block must produce for it.
  function automatic bsc_pkg::res_t predict_bitmap_op(input bsc_pkg::req_t r);
    bsc_pkg::res_t o;
    int unsigned   idx;
    int unsigned   last;
    logic [2:0]    bit_idx;
    logic [7:0]    old;
    o = '0;
    idx = 32'(r.bit_offset[15:3]);
    bit_idx = r.bit_offset[2:0];
    case (r.mode)
      bsc_pkg::MODE_SET: begin
        if (idx >= STORE_BYTES) begin
          o.out_of_range = 1'b1;
        end else begin
          old = stored_byte(idx);
          o.changed = (old[bit_idx] != r.bit_value);
          old[bit_idx] = r.bit_value;
          bm_bytes[idx] = old;
          bm_marked[idx] = 1'b1;
          if (idx >= bm_len) bm_len = idx + 1;
        end
      end
      bsc_pkg::MODE_GET: begin
        old = stored_byte(idx);
        o.bit_out = old[bit_idx];
      end
      bsc_pkg::MODE_COUNT_ALL: begin
        if (bm_len != 0) o.ones_count = 16'(ones_over_bytes(0, bm_len - 1));
      end
      bsc_pkg::MODE_COUNT_RANGE: begin
        if (r.start_byte <= r.end_byte && r.start_byte < bm_len) begin
          last = (32'(r.end_byte) >= bm_len) ? bm_len - 1 : 32'(r.end_byte);
          o.ones_count = 16'(ones_over_bytes(32'(r.start_byte), last));
        end
      end
      bsc_pkg::MODE_CLEAR: begin
        foreach (bm_marked[i]) bm_marked[i] = 1'b0;
        bm_len = 0;
      end
      default: begin
      end
    endcase
    o.length_bytes = bm_len[12:0];
    o.is_empty = (bm_len == 0);
    return o;
  endfunction

  function automatic bsc_pkg::req_t make_req(input logic [2:0] mode,
                                             input int unsigned offset,
                                             input bit value, input int unsigned first,
                                             input int unsigned last);
    bsc_pkg::req_t r;
    r.mode = mode;
    r.bit_offset = offset[15:0];
    r.bit_value = value;
    r.start_byte = first[15:0];
    r.end_byte = last[15:0];
    return r;
  endfunction

  // Random request whose bit positions and ranges mostly fall inside a window
  // of win_bytes bytes, so that sets, gets and counts keep hitting each other.
  // Fields that the chosen mode ignores still carry random values.
  function automatic bsc_pkg::req_t random_request(input int unsigned win_bytes);
    bsc_pkg::req_t r;
    int unsigned   pick;
    pick = $urandom_range(99);
    r.bit_value = 1'($urandom_range(1));
    r.start_byte = 16'($urandom_range(16'hFFFF));
    r.end_byte = 16'($urandom_range(16'hFFFF));
    r.bit_offset = 16'($urandom_range(win_bytes * 8 - 1));
    if (pick < 40) begin
      r.mode = bsc_pkg::MODE_SET;
      // Now and then aim past the capacity; such a set must change nothing.
      if ($urandom_range(19) == 0) r.bit_offset = 16'(32'h8000 | $urandom_range(16'h7FFF));
    end else if (pick < 65) begin
      r.mode = bsc_pkg::MODE_GET;
      if ($urandom_range(9) == 0) r.bit_offset = 16'($urandom_range(16'hFFFF));
    end else if (pick < 73) begin
      r.mode = bsc_pkg::MODE_COUNT_ALL;
    end else if (pick < 86) begin
      r.mode = bsc_pkg::MODE_COUNT_RANGE;
      case ($urandom_range(5))
        0: begin
          // Keep the fully random bounds: mostly reversed or past the length.
        end
        1: begin
          r.end_byte = 16'($urandom_range(win_bytes - 1));
          r.start_byte = 16'(32'(r.end_byte) + 1 + $urandom_range(7));
        end
        default: begin
          r.start_byte = 16'($urandom_range(win_bytes - 1));
          r.end_byte = 16'(32'(r.start_byte) + $urandom_range(win_bytes / 2));
        end
      endcase
    end else if (pick < 89) begin
      r.mode = bsc_pkg::MODE_CLEAR;
    end else if (pick < 96) begin
      r.mode = bsc_pkg::MODE_STATUS;
    end else begin
      r.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
    end
    return r;
  endfunction

  // Offers one request, with random idle cycles ahead of it, and returns at
  // the rising edge where the block takes it. Valid stays high on return so a
  // back-to-back request never drops it for a cycle.
  task automatic send_request(input bsc_pkg::req_t r);
    @(negedge clk);
    while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_results.push_back(predict_bitmap_op(r));
    sent_count++;
  endtask

  // Sender pause: drop valid and wait until every result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every mode and the corner cases, starting from an empty
  // bitmap. It includes one set at the top byte, which grows the bitmap to the
  // full capacity and makes the following count walk all of it.
  task automatic test_directed_edges();
    send_request(make_req(bsc_pkg::MODE_STATUS, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_ALL, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 0, 16'hFFFF));
    send_request(make_req(bsc_pkg::MODE_SET, 0, 1'b1, 0, 0));
    send_request(make_req(bsc_pkg::MODE_SET, 0, 1'b1, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 0, 1'b0, 0, 0));
    // Byte 2 grows the bitmap past byte 1, which must read as zero.
    send_request(make_req(bsc_pkg::MODE_SET, 23, 1'b1, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 8, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 24, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_ALL, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 2, 1));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 1, 16'hFFFF));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 3, 3));
    send_request(make_req(bsc_pkg::MODE_SET, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_SET, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_SET, 32768, 1'b1, 16'hFFFF, 16'hFFFF));
    send_request(make_req(bsc_pkg::MODE_SET, 16'hFFFF, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_SET, 32767, 1'b1, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 32767, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_ALL, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 4095, 4095));
    send_request(make_req(bsc_pkg::MODE_CLEAR, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    send_request(make_req(bsc_pkg::MODE_GET, 23, 1'b0, 0, 0));
    send_request(make_req(MODE_SPARE_6, 16'hFFFF, 1'b1, 16'hFFFF, 0));
    send_request(make_req(MODE_SPARE_7, 5, 1'b1, 0, 16'hFFFF));
    wait_results_drained();
  endtask

  // After a clear, bytes that a later set grows over must read as zero even
  // though the store still holds their old contents.
  task automatic test_clear_regrow();
    for (int i = 0; i < 6; i++) begin
      send_request(make_req(bsc_pkg::MODE_SET, i * 9, 1'b1, 0, 0));
    end
    send_request(make_req(bsc_pkg::MODE_COUNT_ALL, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_CLEAR, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_SET, 8 * 8 + 3, 1'b1, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_GET, 9, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_ALL, 0, 1'b0, 0, 0));
    send_request(make_req(bsc_pkg::MODE_COUNT_RANGE, 0, 1'b0, 0, 8));
    send_request(make_req(bsc_pkg::MODE_STATUS, 0, 1'b0, 0, 0));
    wait_results_drained();
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the queue fills and the block has to stall its request side.
  task automatic test_result_holdoff();
    req_idle_pct = 0;
    hold_asked++;
    repeat (24) send_request(random_request(32));
    wait_results_drained();
    req_idle_pct = IDLE_PCT;
  endtask

  // Random episodes. Each one mostly starts from a clear and works within a
  // window of bytes: small windows most of the time, and at most a few
  // episodes over the whole store, since long bitmaps make counts slow.
  task automatic test_random_episodes(input int target);
    int unsigned win;
    int          big_left;
    bit          was_big;
    big_left = 3;
    was_big = 1'b0;
    while (sent_count < target) begin
      // One stretch runs with no idle cycles on either side.
      req_idle_pct = (sent_count >= 700 && sent_count < 1000) ? 0 : IDLE_PCT;
      res_idle_pct = req_idle_pct;
      if (was_big || $urandom_range(9) < 7)
        send_request(make_req(bsc_pkg::MODE_CLEAR, $urandom_range(16'hFFFF),
                              1'($urandom_range(1)),
                              $urandom_range(16'hFFFF), $urandom_range(16'hFFFF)));
      was_big = 1'b0;
      if (big_left != 0 && $urandom_range(29) == 0) begin
        win = STORE_BYTES;
        big_left--;
        was_big = 1'b1;
      end else begin
        win = ($urandom_range(9) < 7) ? 32 : 256;
      end
      repeat ($urandom_range(20, 60)) send_request(random_request(win));
    end
    res_idle_pct = IDLE_PCT;
    wait_results_drained();
  endtask

  // Result stall: a counted hold-off when asked for, random idling otherwise.
  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= (res_idle_pct != 0) && ($urandom_range(99) < res_idle_pct);
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every accepted result is matched against the oldest pending prediction.
  always @(posedge clk) begin
    bsc_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, actual %p", $time, res_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("bit_out", 32'(want.bit_out), 32'(res_data.bit_out));
        compare_field("changed", 32'(want.changed), 32'(res_data.changed));
        compare_field("ones_count", 32'(want.ones_count), 32'(res_data.ones_count));
        compare_field("length_bytes", 32'(want.length_bytes),
                      32'(res_data.length_bytes));
        compare_field("is_empty", 32'(want.is_empty), 32'(res_data.is_empty));
        compare_field("out_of_range", 32'(want.out_of_range),
                      32'(res_data.out_of_range));
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_clear_regrow();
    test_result_holdoff();
    test_random_episodes(1750);
    // Nothing is pending; give a late, unrequested result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
